FILE: design/clfp_pkg.sv
// Shared types and constants for the camera link frame protocol engine.
package clfp_pkg;

   localparam int MARK_TOTAL  = 3;
   localparam int PAYLOAD_MAX = 255;

   localparam logic [7:0] HEAD_BYTE = 8'h7E;
   localparam logic [7:0] TAIL_BYTE = 8'h7F;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [55:0] TOK_RDY   = 56'h796472;
   localparam logic [55:0] TOK_STP   = 56'h707473;
   localparam logic [55:0] TOK_OK    = 56'h6B6F;
   localparam logic [55:0] TOK_POS   = 56'h736F70;
   localparam logic [55:0] TOK_END   = 56'h646E65;
   localparam logic [23:0] TOK_ERR   = 24'h727265;
   localparam logic [55:0] TOK_ERR0  = 56'h30727265;
   localparam logic [55:0] TOK_ERR33 = 56'h335F33727265;

   typedef enum logic [1:0] {DF_HEAD, DF_LEN, DF_DATA, DF_TAIL} deframe_type;

   typedef enum logic [2:0] {
      NP_PREFIX, NP_COLON, NP_SIGN, NP_POS, NP_NEG, NP_POS_END, NP_NEG_END, NP_DEAD
   } num_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BUSY, ST_RDY, ST_CATQ, ST_STOP, ST_POS, ST_RETRY, ST_DONE, ST_ERR
   } status_type;

   typedef enum logic [3:0] {
      FN_RX, FN_INIT, FN_HANDSHAKE, FN_START, FN_GO, FN_CLASS_REPLY,
      FN_BACK_SEARCH, FN_FORCE_IDLE, FN_SEND_END
   } func_type;

   typedef enum logic [2:0] {
      TX_NONE, TX_P0, TX_P1, TX_P2, TX_P3, TX_GO, TX_CLS, TX_END
   } tx_type;

   typedef enum logic [1:0] {PROC_ONE, PROC_TWO, PROC_THREE, PROC_NONE} proc_type;
   typedef enum logic [2:0] {P1_CAT, P1_WSTOP, P1_WPOS, P1_ITER, P1_WANG} p1_type;
   typedef enum logic [2:0] {
      P2_WRDY, P2_IDLE, P2_WGO, P2_SRCH, P2_PDET, P2_ALIGN
   } p2_type;
   typedef enum logic [1:0] {P3_PH1, P3_PH2, P3_WANG} p3_type;

   typedef struct packed {
      logic step;
      logic flush;
   } rx_ctl_type;

   typedef struct packed {
      logic        frame_ok;
      logic [55:0] token;
      logic        num_ok;
      logic [31:0] num_value;
   } rx_info_type;

endpackage

FILE: design/camera_link_frame_protocol.sv
// Top level: camera link frame protocol engine with host command handling.
// Throughput: one request per cycle unless the response stalls; each item
// passes an input register, one pass of frame/command logic and the
// response register.
// Reset: synchronous, active high; clears link, process and deframer state.
// A stalled response holds the pipeline; the input register then stalls.
module camera_link_frame_protocol import clfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_func,
   input  logic [7:0]         req_rx_byte,
   input  logic [1:0]         req_process_sel,
   input  logic signed [31:0] req_class_request,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_status,
   output logic signed [31:0] rsp_offset_x,
   output logic signed [31:0] rsp_offset_y,
   output logic signed [31:0] rsp_angle_hundredths,
   output logic               rsp_angle_ok,
   output logic signed [31:0] rsp_class_found,
   output logic [3:0]         rsp_mark_number,
   output logic [7:0]         rsp_retry_total,
   output logic [2:0]         rsp_tx_request,
   output logic [55:0]        rsp_error_text,
   output logic               rsp_handshake_done,
   output logic               rsp_frame_seen
);

   logic        req_valid_ff;
   logic [3:0]  req_func_ff;
   logic [7:0]  req_byte_ff;
   logic [1:0]  req_sel_ff;
   logic        rsp_valid_ff;
   logic        adv;
   func_type    fn;
   rx_ctl_type  rx_ctl;
   rx_info_type rx;

   status_type  status_ff, status_in;
   proc_type    proc_ff, proc_in;
   p1_type      p1_ff, p1_in;
   p2_type      p2_ff, p2_in;
   p3_type      p3_ff, p3_in;
   logic        coll_ff, coll_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] temp_ff [3];
   logic [31:0] temp_in [3];
   logic [31:0] x_ff, x_in, y_ff, y_in, ang_ff, ang_in, cls_ff, cls_in;
   logic        ang_ok_ff, ang_ok_in;
   logic        ready_ff, ready_in;
   logic [3:0]  mark_ff, mark_in;
   logic [7:0]  retry_ff, retry_in;
   logic [55:0] err_ff, err_in;
   tx_type      tx_ff, tx_in;
   logic        seen_ff, seen_in;
   logic        tok_err;
   logic        located;

   assign adv       = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !adv;
   assign fn        = func_type'(req_func_ff);

   assign rx_ctl.step  = adv && (fn == FN_RX);
   assign rx_ctl.flush = adv && ((fn == FN_INIT) || (fn == FN_HANDSHAKE) ||
                                 (fn == FN_START) || (fn == FN_FORCE_IDLE));

   clfp_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rx_ctl),
      .rx_byte (req_byte_ff),
      .info    (rx)
   );

   assign tok_err = (rx.token[23:0] == TOK_ERR);
   assign located = (p2_ff == P2_PDET) || (p2_ff == P2_ALIGN);

   always_comb begin
      status_in = status_ff;
      proc_in   = proc_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      p3_in     = p3_ff;
      coll_in   = coll_ff;
      cnt_in    = cnt_ff;
      temp_in   = temp_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      ang_in    = ang_ff;
      cls_in    = cls_ff;
      ang_ok_in = ang_ok_ff;
      ready_in  = ready_ff;
      mark_in   = mark_ff;
      retry_in  = retry_ff;
      err_in    = err_ff;
      tx_in     = TX_NONE;
      seen_in   = 1'b0;

      if (adv && ((fn == FN_INIT) || (fn == FN_START) || (fn == FN_FORCE_IDLE))) begin
         status_in = ST_IDLE;
         proc_in   = PROC_ONE;
         p1_in     = P1_WSTOP;
         p2_in     = P2_IDLE;
         p3_in     = P3_PH1;
         mark_in   = '0;
         retry_in  = '0;
         coll_in   = 1'b0;
         cnt_in    = '0;
         x_in      = '0;
         y_in      = '0;
         ang_in    = '0;
         cls_in    = '0;
         ang_ok_in = 1'b0;
         err_in    = '0;
      end

      if (adv) begin
         case (fn)
            FN_RX: begin
               if (rx.frame_ok) begin
                  seen_in = 1'b1;
                  if (status_ff == ST_IDLE) begin
                     if (rx.token == TOK_RDY) ready_in = 1'b1;
                     if (rx.token == TOK_ERR0) begin
                        status_in = ST_ERR;
                        err_in    = rx.token;
                     end
                  end else if (proc_ff == PROC_ONE) begin
                     if (tok_err) begin
                        coll_in   = 1'b0;
                        status_in = ST_ERR;
                        err_in    = rx.token;
                     end else if (p1_ff == P1_CAT) begin
                        if (rx.token == TOK_RDY) status_in = ST_CATQ;
                     end else if (rx.token == TOK_STP) begin
                        coll_in = 1'b0;
                        if (p1_ff == P1_WSTOP) status_in = ST_STOP;
                     end else if (rx.token == TOK_OK) begin
                        coll_in = 1'b0;
                        if (p1_ff == P1_ITER) p1_in = P1_WANG;
                     end else if (p1_ff == P1_WANG) begin
                        if (rx.num_ok) begin
                           ang_in    = rx.num_value;
                           ang_ok_in = 1'b1;
                           status_in = ST_DONE;
                        end
                     end else if (rx.token == TOK_POS) begin
                        coll_in = 1'b1;
                        cnt_in  = '0;
                        temp_in = '{default: 32'd0};
                     end else if (rx.token == TOK_END) begin
                        if (coll_ff) begin
                           coll_in   = 1'b0;
                           x_in      = temp_ff[0];
                           y_in      = temp_ff[1];
                           ang_in    = '0;
                           ang_ok_in = 1'b0;
                           cls_in    = (p1_ff == P1_WPOS) ? temp_ff[2] : 32'hFFFF_FFFF;
                           status_in = ST_POS;
                        end
                     end else if (coll_ff) begin
                        if (rx.num_ok && (cnt_ff < 8'd3)) temp_in[cnt_ff[1:0]] = rx.num_value;
                        if (cnt_ff != 8'hFF) cnt_in = cnt_ff + 8'd1;
                     end
                  end else if (proc_ff == PROC_TWO) begin
                     if (tok_err) begin
                        coll_in   = 1'b0;
                        status_in = ST_ERR;
                        err_in    = rx.token;
                     end else if (rx.token == TOK_RDY) begin
                        if (p2_ff == P2_WRDY) status_in = ST_RDY;
                     end else if (rx.token == TOK_STP) begin
                        if ((p2_ff == P2_SRCH) || (p2_ff == P2_WRDY)) begin
                           coll_in   = 1'b0;
                           status_in = ST_STOP;
                           p2_in     = P2_SRCH;
                        end
                     end else if (rx.token == TOK_OK) begin
                        coll_in = 1'b0;
                        if (p2_ff == P2_ALIGN) begin
                           if (mark_ff != 4'hF) mark_in = mark_ff + 4'd1;
                           if (mark_in >= 4'(MARK_TOTAL)) begin
                              status_in = ST_DONE;
                           end else begin
                              p2_in     = P2_WGO;
                              status_in = ST_STOP;
                           end
                        end
                     end else if (rx.token == TOK_POS) begin
                        if (located) begin
                           coll_in = 1'b1;
                           cnt_in  = '0;
                           temp_in = '{default: 32'd0};
                        end
                     end else if (rx.token == TOK_END) begin
                        if (coll_ff) begin
                           coll_in = 1'b0;
                           if (located) begin
                              x_in      = temp_ff[0];
                              y_in      = temp_ff[1];
                              ang_in    = '0;
                              ang_ok_in = 1'b0;
                              cls_in    = 32'hFFFF_FFFF;
                              status_in = ST_POS;
                           end
                        end
                     end else if (coll_ff) begin
                        if (rx.num_ok && (cnt_ff < 8'd2)) temp_in[cnt_ff[1:0]] = rx.num_value;
                        if (cnt_ff != 8'hFF) cnt_in = cnt_ff + 8'd1;
                     end
                  end else if (proc_ff == PROC_THREE) begin
                     if (tok_err) begin
                        coll_in = 1'b0;
                        if (rx.token == TOK_ERR33) begin
                           status_in = ST_RETRY;
                           if (retry_ff != 8'hFF) retry_in = retry_ff + 8'd1;
                        end else begin
                           status_in = ST_ERR;
                           err_in    = rx.token;
                        end
                     end else if (p3_ff == P3_WANG) begin
                        if (rx.num_ok) begin
                           ang_in    = rx.num_value;
                           ang_ok_in = 1'b1;
                           status_in = ST_DONE;
                        end
                     end else if (rx.token == TOK_OK) begin
                        coll_in = 1'b0;
                        if (p3_ff == P3_PH2) p3_in = P3_WANG;
                     end else if (rx.token == TOK_POS) begin
                        coll_in = 1'b1;
                        cnt_in  = '0;
                        temp_in = '{default: 32'd0};
                     end else if (rx.token == TOK_END) begin
                        if (coll_ff) begin
                           coll_in   = 1'b0;
                           x_in      = temp_ff[0];
                           y_in      = temp_ff[1];
                           ang_in    = '0;
                           ang_ok_in = 1'b0;
                           cls_in    = 32'hFFFF_FFFF;
                           status_in = ST_POS;
                        end
                     end else if (coll_ff) begin
                        if (rx.num_ok && (cnt_ff < 8'd2)) temp_in[cnt_ff[1:0]] = rx.num_value;
                        if (cnt_ff != 8'hFF) cnt_in = cnt_ff + 8'd1;
                     end
                  end
               end
            end
            FN_INIT: ready_in = 1'b0;
            FN_HANDSHAKE: begin
               ready_in  = 1'b0;
               status_in = ST_IDLE;
               tx_in     = TX_P0;
            end
            FN_START: begin
               proc_in = proc_type'(req_sel_ff);
               case (proc_type'(req_sel_ff))
                  PROC_ONE: begin
                     p1_in     = P1_CAT;
                     status_in = ST_BUSY;
                     tx_in     = TX_P1;
                  end
                  PROC_TWO: begin
                     p2_in     = P2_WRDY;
                     status_in = ST_BUSY;
                     tx_in     = TX_P2;
                  end
                  PROC_THREE: begin
                     p3_in     = P3_PH1;
                     status_in = ST_BUSY;
                     tx_in     = TX_P3;
                  end
                  default: status_in = ST_IDLE;
               endcase
            end
            FN_GO: begin
               if ((proc_ff == PROC_TWO) && (status_ff == ST_IDLE) && (p2_ff == P2_IDLE)) begin
                  p2_in     = P2_SRCH;
                  status_in = ST_BUSY;
                  tx_in     = TX_GO;
               end else if ((status_ff == ST_RDY) && (p2_ff == P2_WRDY)) begin
                  p2_in     = P2_SRCH;
                  status_in = ST_BUSY;
                  tx_in     = TX_GO;
               end else if (status_ff == ST_RETRY) begin
                  status_in = ST_BUSY;
                  tx_in     = TX_GO;
               end else if ((status_ff == ST_STOP) || (status_ff == ST_POS)) begin
                  case (proc_ff)
                     PROC_ONE: begin
                        if (p1_ff == P1_WSTOP) p1_in = P1_WPOS;
                        else if (p1_ff == P1_WPOS) p1_in = P1_ITER;
                     end
                     PROC_TWO: begin
                        if (p2_ff == P2_WGO) p2_in = P2_SRCH;
                        else if (p2_ff == P2_SRCH) p2_in = P2_PDET;
                        else if (p2_ff == P2_PDET) p2_in = P2_ALIGN;
                     end
                     PROC_THREE: begin
                        if (p3_ff == P3_PH1) p3_in = P3_PH2;
                     end
                     default: ;
                  endcase
                  status_in = ST_BUSY;
                  tx_in     = TX_GO;
               end
            end
            FN_CLASS_REPLY: begin
               if ((status_ff == ST_CATQ) && (proc_ff == PROC_ONE)) begin
                  p1_in     = P1_WSTOP;
                  status_in = ST_BUSY;
                  tx_in     = TX_CLS;
               end
            end
            FN_BACK_SEARCH: begin
               if (proc_ff == PROC_TWO) begin
                  p2_in     = P2_SRCH;
                  status_in = ST_BUSY;
                  coll_in   = 1'b0;
               end
            end
            FN_FORCE_IDLE: ;
            FN_SEND_END: tx_in = TX_END;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_IDLE;
         proc_ff      <= PROC_ONE;
         p1_ff        <= P1_WSTOP;
         p2_ff        <= P2_IDLE;
         p3_ff        <= P3_PH1;
         coll_ff      <= 1'b0;
         cnt_ff       <= '0;
         temp_ff      <= '{default: 32'd0};
         x_ff         <= '0;
         y_ff         <= '0;
         ang_ff       <= '0;
         cls_ff       <= '0;
         ang_ok_ff    <= 1'b0;
         ready_ff     <= 1'b0;
         mark_ff      <= '0;
         retry_ff     <= '0;
         err_ff       <= '0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         status_ff <= status_in;
         proc_ff   <= proc_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         coll_ff   <= coll_in;
         cnt_ff    <= cnt_in;
         temp_ff   <= temp_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         ang_ff    <= ang_in;
         cls_ff    <= cls_in;
         ang_ok_ff <= ang_ok_in;
         ready_ff  <= ready_in;
         mark_ff   <= mark_in;
         retry_ff  <= retry_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_func_ff  <= req_func;
         req_byte_ff  <= req_rx_byte;
         req_sel_ff   <= req_process_sel;
      end
      if (adv) begin
         tx_ff   <= tx_in;
         seen_ff <= seen_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_offset_x         = x_ff;
   assign rsp_offset_y         = y_ff;
   assign rsp_angle_hundredths = ang_ff;
   assign rsp_angle_ok         = ang_ok_ff;
   assign rsp_class_found      = cls_ff;
   assign rsp_mark_number      = mark_ff;
   assign rsp_retry_total      = retry_ff;
   assign rsp_tx_request       = tx_ff;
   assign rsp_error_text       = err_ff;
   assign rsp_handshake_done   = ready_ff;
   assign rsp_frame_seen       = seen_ff;

endmodule

FILE: design/clfp_rx.sv
// Deframer with token capture and N:[-]digits number parser.
module clfp_rx import clfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rx_ctl_type  ctl,
   input  logic [7:0]  rx_byte,
   output rx_info_type info
);

   deframe_type phase_ff, phase_in;
   num_type     np_ff, np_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [55:0] tok_ff, tok_in;
   logic        zero_ff, zero_in;
   logic [31:0] acc_ff, acc_in;
   logic        is_digit;
   logic [31:0] digit;

   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digit    = {28'd0, rx_byte[3:0]};

   always_comb begin
      phase_in = phase_ff;
      np_in    = np_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      tok_in   = tok_ff;
      zero_in  = zero_ff;
      acc_in   = acc_ff;
      if (ctl.flush) begin
         phase_in = DF_HEAD;
      end else if (ctl.step) begin
         case (phase_ff)
            DF_HEAD: begin
               if (rx_byte == HEAD_BYTE) begin
                  phase_in = DF_LEN;
                  idx_in   = '0;
                  len_in   = '0;
                  tok_in   = '0;
                  zero_in  = 1'b0;
                  acc_in   = '0;
                  np_in    = NP_PREFIX;
               end
            end
            DF_LEN: begin
               len_in = rx_byte;
               if (rx_byte == 8'd0) begin
                  phase_in = DF_TAIL;
               end else if ({1'b0, rx_byte} > 9'(PAYLOAD_MAX)) begin
                  phase_in = DF_HEAD;
               end else begin
                  phase_in = DF_DATA;
               end
            end
            DF_DATA: begin
               if (!zero_ff) begin
                  if (rx_byte == 8'd0) begin
                     zero_in = 1'b1;
                  end else begin
                     if (idx_ff < 8'd7) begin
                        tok_in = tok_ff | (56'(rx_byte) << {idx_ff[2:0], 3'b000});
                     end
                     case (np_ff)
                        NP_PREFIX: np_in = (rx_byte == CHAR_N) ? NP_COLON : NP_DEAD;
                        NP_COLON:  np_in = (rx_byte == CHAR_COLON) ? NP_SIGN : NP_DEAD;
                        NP_SIGN: begin
                           if (rx_byte == CHAR_MINUS) begin
                              np_in = NP_NEG;
                           end else if (is_digit) begin
                              acc_in = digit;
                              np_in  = NP_POS;
                           end else begin
                              np_in = NP_POS_END;
                           end
                        end
                        NP_POS, NP_NEG: begin
                           if (is_digit) begin
                              acc_in = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + digit;
                           end else begin
                              np_in = (np_ff == NP_POS) ? NP_POS_END : NP_NEG_END;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               idx_in = idx_ff + 8'd1;
               if (idx_in >= len_ff) begin
                  phase_in = DF_TAIL;
               end
            end
            default: phase_in = DF_HEAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DF_HEAD;
         np_ff    <= NP_PREFIX;
         len_ff   <= '0;
         idx_ff   <= '0;
         tok_ff   <= '0;
         zero_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         np_ff    <= np_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         tok_ff   <= tok_in;
         zero_ff  <= zero_in;
         acc_ff   <= acc_in;
      end
   end

   always_comb begin
      info.frame_ok  = ctl.step && (phase_ff == DF_TAIL) && (rx_byte == TAIL_BYTE);
      info.token     = tok_ff;
      info.num_ok    = (np_ff == NP_SIGN) || (np_ff == NP_POS) || (np_ff == NP_NEG) ||
                       (np_ff == NP_POS_END) || (np_ff == NP_NEG_END);
      info.num_value = ((np_ff == NP_NEG) || (np_ff == NP_NEG_END)) ? (32'd0 - acc_ff) : acc_ff;
   end

endmodule

FILE: design/clfp_checker.sv
// Port-level checker for the camera link frame protocol engine, with bind.
module clfp_checker import clfp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_status,
   input logic [2:0] rsp_tx_request,
   input logic       rsp_frame_seen
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response transfer dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_frame_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_seen |-> rsp_tx_request == TX_NONE)
      else $error("frame completion and transmit request in one response");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tx_request == TX_GO) |-> rsp_status == ST_BUSY)
      else $error("go transmit without busy status");

endmodule

bind camera_link_frame_protocol clfp_checker u_clfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_tx_request (rsp_tx_request),
   .rsp_frame_seen (rsp_frame_seen)
);
